/* rtl/psd_pkg.sv */
// shared types and constants of the pencil sketch dodge filter
// no dependencies; used by every module of the block
`default_nettype none

package psd_pkg;

  localparam int PIX_W     = 8;
  localparam int WCFG_W    = 11;
  localparam int H_W       = 16;
  localparam int ROW_W     = H_W + 1;
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 1;
  localparam int DVD_W     = 2 * PIX_W;

  localparam logic [PIX_W-1:0]     PIX_MAX = '1;
  localparam logic [WCFG_W-1:0]    FRAME_WIDTH_RST  = 11'd640;
  localparam logic [H_W-1:0]       FRAME_HEIGHT_RST = 16'd480;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic accept;
    logic calc;
    logic div_start;
    logic load_out;
  } psd_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_busy;
    logic out_free;
  } psd_stat_t;

endpackage

`default_nettype wire

/* rtl/psd_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on psd_pkg for operand widths
`default_nettype none

module psd_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [psd_pkg::DVD_W-1:0] dividend_i,
  input  wire logic [psd_pkg::PIX_W-1:0] divisor_i,
  output logic                           busy_o,
  output logic [psd_pkg::DVD_W-1:0]      quotient_o
);
  import psd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PIX_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [PIX_W:0]   trial;
  logic [PIX_W:0]   dvs_x;
  logic             fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign dvs_x = {1'b0, divisor_i};
  assign fits  = trial >= dvs_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? PIX_W'(trial - dvs_x) : trial[PIX_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/psd_datapath.sv */
// datapath: config registers, line store banks, column minimum window,
// position counters, dodge divider and output register; uses psd_pkg, psd_div
`default_nettype none

module psd_datapath #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [psd_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [psd_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          op_i,
  input  wire logic [psd_pkg::PIX_W-1:0]     pixel_i,
  input  wire psd_pkg::psd_cmd_t             cmd_i,
  output psd_pkg::psd_stat_t                 stat_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [psd_pkg::PIX_W-1:0]          sketch_pixel_o,
  output logic                               frame_end_o
);
  import psd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CXW = (CW + 1 > WCFG_W) ? CW + 1 : WCFG_W;
  localparam int PW  = CXW + H_W;
  localparam int RX  = ROW_W + 1;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // configuration
  logic [WCFG_W-1:0] fw_q;
  logic [H_W-1:0]    fh_q;
  logic [CXW-1:0]    fw_x;
  logic [CXW-1:0]    max_x;
  logic [CXW-1:0]    w_eff;
  logic [H_W-1:0]    h_eff;
  logic [PW-1:0]     prod_q;

  // frame state
  logic [CW-1:0]     c_q;
  logic [ROW_W-1:0]  r_q;
  logic [1:0]        slot_q;
  logic [PW-1:0]     pos_q;
  logic [PIX_W-1:0]  win_q [4];
  logic [PIX_W-1:0]  cd0_q;

  // item
  logic              op_q;
  logic [PIX_W-1:0]  pix_q;
  logic [PIX_W-1:0]  m_q;
  logic [PIX_W-1:0]  ctr_q;
  logic              fend_q;

  // line store
  logic [PIX_W-1:0]  bank0 [MAX_WIDTH];
  logic [PIX_W-1:0]  bank1 [MAX_WIDTH];
  logic [PIX_W-1:0]  bank2 [MAX_WIDTH];
  logic [PIX_W-1:0]  rd0_q;
  logic [PIX_W-1:0]  rd1_q;
  logic [PIX_W-1:0]  rd2_q;
  logic [PIX_W-1:0]  d1;
  logic [PIX_W-1:0]  d2;
  logic [PIX_W-1:0]  d3;

  // per item decode
  logic [RX-1:0]     r_x;
  logic [RX-1:0]     h_x;
  logic              v1;
  logic              v2;
  logic              v3;
  logic              present;
  logic              skip;
  logic              upd;
  logic              wr_en;
  logic              emit;
  logic              ending;
  logic              last_col;
  logic [CXW-1:0]    c_next;
  logic [PIX_W-1:0]  colmin;
  logic [PIX_W-1:0]  m;
  logic [PIX_W-1:0]  pix_inv;

  // divider and result
  logic              div_busy;
  logic [DVD_W-1:0]  quo;
  logic [DVD_W-1:0]  dividend;
  logic [DVD_W:0]    sum;
  logic [PIX_W-1:0]  res;
  logic              out_valid_q;
  logic [PIX_W-1:0]  sketch_q;
  logic              frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  fw_q <= cfg_data_i[WCFG_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i[H_W-1:0];
        default: ;
      endcase
    end
  end

  assign fw_x  = CXW'(fw_q);
  assign max_x = CXW'(MAX_WIDTH);
  assign w_eff = (fw_q == '0) ? CXW'(1) : ((fw_x > max_x) ? max_x : fw_x);
  assign h_eff = (fh_q == '0) ? H_W'(1) : fh_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(w_eff) * PW'(h_eff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      pix_q <= pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (slot_q)
        2'd0:    bank0[c_q] <= pix_q;
        2'd1:    bank1[c_q] <= pix_q;
        2'd2:    bank2[c_q] <= pix_q;
        default: ;
      endcase
    end
    rd0_q <= bank0[c_q];
    rd1_q <= bank1[c_q];
    rd2_q <= bank2[c_q];
  end

  // rows r-1, r-2, r-3 by slot of row r
  always_comb begin
    case (slot_q)
      2'd0: begin
        d1 = rd2_q; d2 = rd1_q; d3 = rd0_q;
      end
      2'd1: begin
        d1 = rd0_q; d2 = rd2_q; d3 = rd1_q;
      end
      2'd2: begin
        d1 = rd1_q; d2 = rd0_q; d3 = rd2_q;
      end
      default: begin
        d1 = rd0_q; d2 = rd1_q; d3 = rd2_q;
      end
    endcase
  end

  assign r_x     = RX'(r_q);
  assign h_x     = RX'(h_eff);
  assign v1      = (r_q >= ROW_W'(1)) && (r_x < h_x + RX'(1));
  assign v2      = (r_q >= ROW_W'(2)) && (r_x < h_x + RX'(2));
  assign v3      = (r_q >= ROW_W'(3)) && (r_x < h_x + RX'(3));
  assign present = r_x < h_x;
  assign skip    = present && (op_q == OP_DRAIN);
  assign upd     = cmd_i.calc && !skip;
  assign wr_en   = upd && present;
  assign pix_inv = ~pix_q;

  always_comb begin
    colmin = PIX_MAX;
    if (v1) colmin = min2(colmin, ~d1);
    if (v2) colmin = min2(colmin, ~d2);
    if (v3) colmin = min2(colmin, ~d3);
    if (present) colmin = min2(colmin, pix_inv);
  end

  always_comb begin
    m = min2(win_q[1], min2(win_q[2], win_q[3]));
    if (c_q != '0) begin
      m = min2(m, colmin);
    end
  end

  assign emit     = (r_q >= ROW_W'(2)) || ((r_q == ROW_W'(1)) && (c_q != '0));
  assign ending   = emit && ({1'b0, pos_q} + (PW+1)'(1) >= {1'b0, prod_q});
  assign c_next   = CXW'(c_q) + CXW'(1);
  assign last_col = c_next >= w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q    <= '0;
      r_q    <= '0;
      slot_q <= '0;
      pos_q  <= '0;
      cd0_q  <= '0;
      for (int k = 0; k < 4; k++) win_q[k] <= PIX_MAX;
    end else if (upd) begin
      if (ending) begin
        c_q    <= '0;
        r_q    <= '0;
        slot_q <= '0;
        pos_q  <= '0;
        cd0_q  <= '0;
        for (int k = 0; k < 4; k++) win_q[k] <= PIX_MAX;
      end else begin
        cd0_q <= v1 ? d1 : '0;
        if (c_q == '0) begin
          win_q[0] <= PIX_MAX;
          win_q[1] <= PIX_MAX;
          win_q[2] <= PIX_MAX;
        end else begin
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= win_q[3];
        end
        win_q[3] <= colmin;
        if (emit) pos_q <= pos_q + PW'(1);
        if (last_col) begin
          c_q    <= '0;
          r_q    <= r_q + ROW_W'(1);
          slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
        end else begin
          c_q <= c_next[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      m_q    <= m;
      ctr_q  <= cd0_q;
      fend_q <= ending;
    end
  end

  assign dividend = DVD_W'(ctr_q) * DVD_W'(m_q);

  psd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (~m_q),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign sum = (DVD_W+1)'(ctr_q) + (DVD_W+1)'(quo);
  assign res = ((m_q == PIX_MAX) || (sum > (DVD_W+1)'(PIX_MAX))) ? PIX_MAX : sum[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sketch_q    <= res;
      frame_end_q <= fend_q;
    end
  end

  assign stat_o.emit     = emit && !skip;
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign sketch_pixel_o = sketch_q;
  assign frame_end_o    = frame_end_q;

endmodule

`default_nettype wire

/* rtl/psd_ctrl.sv */
// controller state machine: sequences accept, update, divide and output
// depends on psd_pkg for the command and status structs
`default_nettype none

module psd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output psd_pkg::psd_cmd_t       cmd_o,
  input  wire psd_pkg::psd_stat_t stat_i
);
  import psd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } psd_state_e;

  psd_state_e state_q;
  psd_state_e state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CALC;
      ST_CALC: state_d = stat_i.emit ? ST_LOAD : ST_IDLE;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (!stat_i.div_busy) state_d = ST_OUT;
      ST_OUT:  if (stat_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.calc      = (state_q == ST_CALC);
  assign cmd_o.div_start = (state_q == ST_LOAD);
  assign cmd_o.load_out  = (state_q == ST_OUT) && stat_i.out_free;

endmodule

`default_nettype wire

/* rtl/pencil_sketch_dodge_filter.sv */
// Pencil sketch by color dodge over a grayscale raster stream.
// Input channel: in_valid_i/in_ready_o carry one beat of op_i and pixel_i;
// op_i selects a new pixel or a drain beat that flushes one pending result.
// Output channel: out_valid_o/out_ready_i carry sketch_pixel_o and
// frame_end_o, high on the last result of the frame.
// Results lag one row and one column; after the last pixel of a frame,
// frame_width + 1 drain beats deliver the rest.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i at a clock edge
// (0 = frame_width, 1 = frame_height); write only while the block is idle.
// Sequence: each beat passes the accept and update states; a beat that
// yields a result then passes the load, divide and output states, waiting
// on the bit-serial divider of the dodge step, before the next is taken.
// A new beat is accepted while the output register still holds a result;
// a stalled receiver holds the block only once the next result is ready.
// Reset clears the frame counters and window and restores the register
// defaults 640 x 480; the line store needs no clearing.
// Depends on psd_pkg, psd_ctrl, psd_datapath.
`default_nettype none

module pencil_sketch_dodge_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [psd_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [psd_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [psd_pkg::PIX_W-1:0]     pixel_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [psd_pkg::PIX_W-1:0]          sketch_pixel_o,
  output logic                               frame_end_o
);
  import psd_pkg::*;

  psd_cmd_t  cmd;
  psd_stat_t stat;

  psd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  psd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .pixel_i        (pixel_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .sketch_pixel_o (sketch_pixel_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

`default_nettype wire

/* rtl/psd_checker.sv */
// port-level checks of the pencil sketch dodge filter, bound to the top level
// depends on psd_pkg for payload widths
`default_nettype none

module psd_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [psd_pkg::PIX_W-1:0] sketch_pixel_o,
  input wire logic                      frame_end_o
);

  // stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(sketch_pixel_o) && $stable(frame_end_o)))
    else $error("output beat changed while stalled");

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // one beat in flight: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted back to back");

  // a result never shows up the cycle after an accept
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result too early after accept");

endmodule

bind pencil_sketch_dodge_filter psd_checker u_psd_checker (.*);

`default_nettype wire

/* test/pencil_sketch_dodge_filter_test.sv */
// testbench for pencil_sketch_dodge_filter: streams frames of gray pixels and drain
// beats, predicts every dodged sketch pixel and compares the output beats in order
// depends on psd_pkg and the pencil_sketch_dodge_filter rtl
`timescale 1ns / 100ps

module pencil_sketch_dodge_filter_test;
  import psd_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int MAX_W        = 1024;
  localparam int SETTLE_CYC   = 40;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT_A    = 300;
  localparam int HOLD_AT_B    = 1080;
  localparam int RAND_BEATS   = 300;
  localparam int LIMIT_CYCLES = 1_000_000;

  typedef enum {TONE_MIXED, TONE_DARK, TONE_LIGHT, TONE_BILEVEL} tone_e;

  typedef struct {
    logic        op;
    logic [7:0]  pix;
    int unsigned gap;
    bit          hold_for_results;
  } beat_t;

  typedef struct {
    logic [7:0] sketch;
    logic       frame_end;
  } sketch_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 op_i = OP_PIXEL;
  logic [PIX_W-1:0]     pixel_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     sketch_pixel_o;
  logic                 frame_end_o;

  pencil_sketch_dodge_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .pixel_i       (pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sketch_pixel_o(sketch_pixel_o),
    .frame_end_o   (frame_end_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  beat_t   pixel_beats[$];
  sketch_t pending_sketch[$];
  beat_t   tx_beat;
  sketch_t exp_sk;
  int unsigned tx_idle;
  int unsigned rx_wait;
  int unsigned rx_w;
  bit      idle_on = 1'b1;

  // own copy of the filter state
  logic [7:0]      px_rows [3*MAX_W];
  logic [7:0]      colmin_win [4];
  logic [7:0]      above_dly [2];
  int unsigned     in_row;
  int unsigned     in_col;
  longint unsigned out_pos;
  logic [10:0]     cfg_width = FRAME_WIDTH_RST;
  logic [15:0]     cfg_height = FRAME_HEIGHT_RST;

  int n_err;
  int n_sketch;
  int n_pix_beats;
  int n_drain_beats;
  int n_ignored;
  int n_frames;

  function automatic void restart_sketch();
    colmin_win = '{default: 8'hFF};
    above_dly  = '{default: 8'h00};
    in_row  = 0;
    in_col  = 0;
    out_pos = 0;
  endfunction

  function automatic int unsigned dodge_value(int unsigned s, int unsigned m);
    int unsigned v;
    if (m >= 255) return 255;
    v = s + (s * m) / (255 - m);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic int unsigned clamp_w(int unsigned v);
    return (v == 0) ? 1 : ((v > MAX_W) ? MAX_W : v);
  endfunction

  function automatic int unsigned clamp_h(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // advance the filter by one accepted beat and queue the sketch pixel it yields
  function automatic void compute_sketch(logic op, logic [7:0] pix);
    int unsigned w, h, r, c, k, cmin, v, m, ctr;
    bit present, emit, at_end;
    sketch_t sk;
    w = clamp_w(cfg_width);
    h = clamp_h(cfg_height);
    r = in_row;
    c = in_col;
    present = (r < h);
    if (present && op == OP_DRAIN) begin
      n_ignored++;
      return;
    end
    if (op == OP_DRAIN) n_drain_beats++;
    else n_pix_beats++;
    cmin = 255;
    for (k = 1; k <= 3; k++) begin
      if (r >= k && r - k < h) begin
        v = 255 - px_rows[((r - k) % 3) * MAX_W + c];
        if (v < cmin) cmin = v;
      end
    end
    if (present) begin
      v = 255 - pix;
      if (v < cmin) cmin = v;
      px_rows[(r % 3) * MAX_W + c] = pix;
    end
    above_dly[1] = above_dly[0];
    above_dly[0] = (r >= 1 && r - 1 < h) ? px_rows[((r - 1) % 3) * MAX_W + c] : 8'h00;
    ctr = above_dly[1];
    if (c == 0) begin
      m = colmin_win[1];
      if (colmin_win[2] < m) m = colmin_win[2];
      if (colmin_win[3] < m) m = colmin_win[3];
      colmin_win[0] = 8'hFF;
      colmin_win[1] = 8'hFF;
      colmin_win[2] = 8'hFF;
      colmin_win[3] = 8'(cmin);
    end else begin
      colmin_win[0] = colmin_win[1];
      colmin_win[1] = colmin_win[2];
      colmin_win[2] = colmin_win[3];
      colmin_win[3] = 8'(cmin);
      m = colmin_win[0];
      for (k = 1; k < 4; k++)
        if (colmin_win[k] < m) m = colmin_win[k];
    end
    emit = (r >= 2) || (r == 1 && c >= 1);
    at_end = 1'b0;
    if (emit) begin
      at_end = (out_pos + 1 >= longint'(w) * longint'(h));
      sk.sketch    = 8'(dodge_value(ctr, m));
      sk.frame_end = at_end;
      pending_sketch = {pending_sketch, sk};
      out_pos++;
    end
    if (c + 1 >= w) begin
      in_col = 0;
      in_row = r + 1;
    end else begin
      in_col = c + 1;
    end
    if (at_end) restart_sketch();
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_idle    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) compute_sketch(op_i, pixel_i);
      if (!in_valid_i || in_ready_o) begin
        if (pixel_beats.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (tx_idle < pixel_beats[0].gap) begin
          tx_idle    <= tx_idle + 1;
          in_valid_i <= 1'b0;
        end else if (pixel_beats[0].hold_for_results && pending_sketch.size() != 0) begin
          in_valid_i <= 1'b0;
        end else begin
          tx_beat = pixel_beats.pop_front();
          in_valid_i <= 1'b1;
          op_i       <= tx_beat.op;
          pixel_i    <= tx_beat.pix;
          tx_idle    <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (pending_sketch.size() == 0) begin
        n_err++;
        $display("%t unexpected beat: expected none, got sketch %0d frame_end %0b",
                 $time, sketch_pixel_o, frame_end_o);
      end else begin
        exp_sk = pending_sketch.pop_front();
        if (sketch_pixel_o !== exp_sk.sketch) begin
          n_err++;
          $display("%t sketch_pixel mismatch: expected %0d, got %0d",
                   $time, exp_sk.sketch, sketch_pixel_o);
        end
        if (frame_end_o !== exp_sk.frame_end) begin
          n_err++;
          $display("%t frame_end mismatch: expected %0b, got %0b",
                   $time, exp_sk.frame_end, frame_end_o);
        end
      end
      n_sketch++;
      if (n_sketch == HOLD_AT_A || n_sketch == HOLD_AT_B) rx_w = LONG_HOLD;
      else rx_w = idle_on ? $urandom_range(0, 5) : 0;
      rx_wait     <= rx_w;
      out_ready_i <= (rx_w == 0);
    end else if (rx_wait > 1) begin
      rx_wait     <= rx_wait - 1;
      out_ready_i <= 1'b0;
    end else begin
      rx_wait     <= 0;
      out_ready_i <= 1'b1;
    end
  end

  function automatic void add_beat(logic op, logic [7:0] pix, bit hold_for_results);
    beat_t b;
    b.op  = op;
    b.pix = pix;
    b.gap = idle_on ? $urandom_range(0, 5) : 0;
    b.hold_for_results = hold_for_results;
    pixel_beats = {pixel_beats, b};
  endfunction

  function automatic logic [7:0] pick_pixel(tone_e tone);
    case (tone)
      TONE_MIXED: begin
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
      end
      TONE_DARK:  return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
      TONE_LIGHT: return 8'($urandom_range(200, 255));
      default:    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // one whole frame of pixels, then the w+1 beats that flush it; when noisy, stray drain beats are mixed in
  function automatic void run_frame(int unsigned w, int unsigned h, tone_e tone, bit noisy);
    int unsigned total;
    total = w * h;
    for (int unsigned p = 0; p < total; p++) begin
      if (noisy && $urandom_range(0, 29) == 0) add_beat(OP_DRAIN, 8'($urandom), 1'b0);
      add_beat(OP_PIXEL, pick_pixel(tone), noisy && p == total / 2 && n_frames % 3 == 0);
    end
    for (int unsigned d = 0; d <= w; d++)
      add_beat((noisy && $urandom_range(0, 1)) ? OP_PIXEL : OP_DRAIN, 8'($urandom), 1'b0);
    if (noisy) repeat ($urandom_range(0, 2)) add_beat(OP_DRAIN, 8'($urandom), 1'b0);
    n_frames++;
  endfunction

  task automatic settle();
    while (pixel_beats.size() != 0 || in_valid_i || pending_sketch.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = val[10:0];
    else cfg_height = val;
  endtask

  initial begin
    logic [7:0]  ramp [12];
    int unsigned n_rand, wv, hv;
    tone_e       tone;
    ramp = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
             8'h00, 8'h00, 8'h01, 8'h80, 8'hFE, 8'h00};
    restart_sketch();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero sizes act as 1x1; early drain ignored, late pixel acts as drain
    settle();
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    add_beat(OP_DRAIN, 8'h5A, 1'b0);
    add_beat(OP_PIXEL, 8'hFF, 1'b0);
    add_beat(OP_PIXEL, 8'h00, 1'b0);
    add_beat(OP_DRAIN, 8'hA5, 1'b0);

    settle();
    write_reg(REG_FRAME_WIDTH, 16'd4);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    foreach (ramp[i]) begin
      if (i == 5) add_beat(OP_DRAIN, 8'h33, 1'b0);
      add_beat(OP_PIXEL, ramp[i], 1'b0);
    end
    for (int i = 0; i < 5; i++) add_beat(i[0] ? OP_PIXEL : OP_DRAIN, 8'(i * 51), 1'b0);

    // tallest frame, cut short by a smaller height mid-frame
    settle();
    write_reg(REG_FRAME_WIDTH, 16'd1);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 12; i++) add_beat(OP_PIXEL, pick_pixel(TONE_MIXED), 1'b0);
    settle();
    write_reg(REG_FRAME_HEIGHT, 16'd5);
    add_beat(OP_DRAIN, 8'h00, 1'b0);

    // widest frame at full rate, both sizes clamped
    settle();
    idle_on = 1'b0;
    write_reg(REG_FRAME_WIDTH, 16'h07FF);
    write_reg(REG_FRAME_HEIGHT, 16'd0);
    run_frame(1024, 1, TONE_MIXED, 1'b0);
    settle();
    idle_on = 1'b1;

    n_rand = 0;
    while (n_rand < RAND_BEATS) begin
      if ($urandom_range(0, 1) == 1) begin
        wv = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
        case ($urandom_range(0, 9))
          0:       hv = 0;
          1:       hv = 1;
          default: hv = $urandom_range(2, 10);
        endcase
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(wv) | (CFG_W'($urandom_range(0, 31)) << WCFG_W));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(hv));
      end
      idle_on = ($urandom_range(0, 3) != 0);
      tone = tone_e'($urandom_range(0, 3));
      run_frame(clamp_w(cfg_width), clamp_h(cfg_height), tone, 1'b1);
      n_rand += clamp_w(cfg_width) * clamp_h(cfg_height) + clamp_w(cfg_width) + 1;
    end

    while (pixel_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_sketch.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (pending_sketch.size() != 0) begin
      n_err++;
      $display("%t %0d sketch results never arrived", $time, pending_sketch.size());
    end
    $display("frames: %0d, pixel beats: %0d, drain beats: %0d, ignored drains: %0d",
             n_frames, n_pix_beats, n_drain_beats, n_ignored);
    $display("sketch beats checked: %0d, errors: %0d", n_sketch, n_err);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("%t timeout with %0d sketch results outstanding", $time, pending_sketch.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/psd_pkg.sv
rtl/psd_div.sv
rtl/psd_datapath.sv
rtl/psd_ctrl.sv
rtl/pencil_sketch_dodge_filter.sv
rtl/psd_checker.sv
test/pencil_sketch_dodge_filter_test.sv
